>>> src/life_grid_generation_engine_defines.svh
// ----------------------------------------------------------------------------
// Life grid generation engine assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, held off in reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_ENGINE_DEFINES_SVH
`define LIFE_GRID_GENERATION_ENGINE_DEFINES_SVH

// Assert a property on every rising edge outside reset.
`define LGGE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Assert an implication on every rising edge outside reset.
`define LGGE_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Assert an implication checked on the next rising edge, outside reset.
`define LGGE_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> src/lgge_pkg.sv
// ----------------------------------------------------------------------------
// Life grid package
// Grid dimensions, rule counts and command codes for the generation engine.
// ----------------------------------------------------------------------------
package lgge_pkg;

  localparam int GRID_LINES  = 64;
  localparam int LINE_CELLS  = 64;
  localparam int LINE_BITS_W = 64;
  localparam int IDX_W       = $clog2(GRID_LINES);
  localparam int COUNT_W     = 4;

  localparam logic [COUNT_W-1:0] BIRTH_COUNT   = COUNT_W'(3);
  localparam logic [COUNT_W-1:0] SURVIVE_COUNT = COUNT_W'(2);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_TOGGLE  = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_e;

  typedef logic [LINE_CELLS-1:0] line_t;

endpackage

>>> src/lgge_line_cell.sv
// ----------------------------------------------------------------------------
// Line cell
// One grid line in the rotating chain; loads its neighbour's line on shift.
// ----------------------------------------------------------------------------
module lgge_line_cell
  import lgge_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  shift_i,
  input  line_t line_i,
  output line_t line_o
);

  line_t line_q;
  line_t line_d;

  always_comb begin
    line_d = shift_i ? line_i : line_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q <= '0;
    end else begin
      line_q <= line_d;
    end
  end

  assign line_o = line_q;

endmodule

>>> src/lgge_rule_unit.sv
// ----------------------------------------------------------------------------
// B3/S23 rule unit
// Computes one new line from the old line and its two neighbouring lines.
// ----------------------------------------------------------------------------
module lgge_rule_unit
  import lgge_pkg::*;
(
  input  line_t above_i,
  input  line_t centre_i,
  input  line_t below_i,
  output line_t fresh_o
);

  // Pad with dead cells at both ends: no wrap.
  logic [LINE_CELLS+1:0] above_pad;
  logic [LINE_CELLS+1:0] centre_pad;
  logic [LINE_CELLS+1:0] below_pad;

  assign above_pad  = {1'b0, above_i, 1'b0};
  assign centre_pad = {1'b0, centre_i, 1'b0};
  assign below_pad  = {1'b0, below_i, 1'b0};

  always_comb begin
    logic [COUNT_W-1:0] count;
    fresh_o = '0;
    for (int p = 0; p < LINE_CELLS; p++) begin
      count = COUNT_W'(above_pad[p])  + COUNT_W'(above_pad[p+1]) + COUNT_W'(above_pad[p+2])
            + COUNT_W'(centre_pad[p])                            + COUNT_W'(centre_pad[p+2])
            + COUNT_W'(below_pad[p])  + COUNT_W'(below_pad[p+1]) + COUNT_W'(below_pad[p+2]);
      fresh_o[p] = (count == BIRTH_COUNT) || (centre_i[p] && (count == SURVIVE_COUNT));
    end
  end

endmodule

>>> src/life_grid_generation_engine.sv
// Each command rotates the whole line chain once past the rule unit at the head,
// one line per cycle while the last step is not held; a new command is taken
// only in idle, so the previous sweep must finish before the next one starts.
// A result waiting on out_ready_i holds the last step and the input.
// Reset: asynchronous, active low; all cells dead, no result pending.
// ----------------------------------------------------------------------------
// Life grid generation engine
// Bounded B3/S23 grid held in a rotating chain of line cells.
// ----------------------------------------------------------------------------
`include "life_grid_generation_engine_defines.svh"

module life_grid_generation_engine
  import lgge_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             command_i,
  input  logic [5:0]             x_index_i,
  input  logic [5:0]             y_index_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [LINE_BITS_W-1:0] line_bits_o
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  localparam int               CMP_W = (IDX_W > 6) ? IDX_W : 6;
  localparam logic [IDX_W-1:0] LAST  = IDX_W'(GRID_LINES - 1);

  logic             state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  cmd_e             cmd_q, cmd_d;
  logic [5:0]       x_q, x_d;
  logic [5:0]       y_q, y_d;
  line_t            above_q, above_d;
  line_t            res_q, res_d;
  line_t            out_q, out_d;
  logic             out_valid_q, out_valid_d;

  line_t cell_line [GRID_LINES];
  line_t head;
  line_t above;
  line_t below;
  line_t fresh;
  line_t tail;
  line_t tmask;
  logic  shift;
  logic  hit;
  logic  out_free;
  logic  in_fire;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign shift      = (state_q == ST_SWEEP) && ((cnt_q != LAST) || out_free);

  // Chain: each cell takes the line of cell k+1; the tail takes the new head line.
  for (genvar k = 0; k < GRID_LINES; k++) begin : g_cells
    line_t next_line;
    if (k == GRID_LINES - 1) begin : g_tail
      assign next_line = tail;
    end else begin : g_link
      assign next_line = cell_line[k+1];
    end
    lgge_line_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .line_i (next_line),
      .line_o (cell_line[k])
    );
  end

  assign head  = cell_line[0];
  assign above = (cnt_q == '0) ? '0 : above_q;
  assign below = (cnt_q == LAST) ? '0 : cell_line[1];
  assign tmask = line_t'(1) << y_q;
  assign hit   = (CMP_W'(cnt_q) == CMP_W'(x_q));

  lgge_rule_unit u_rule (
    .above_i (above),
    .centre_i(head),
    .below_i (below),
    .fresh_o (fresh)
  );

  always_comb begin
    case (cmd_q)
      CMD_CLEAR:   tail = '0;
      CMD_TOGGLE:  tail = hit ? (head ^ tmask) : head;
      CMD_ADVANCE: tail = fresh;
      CMD_READ:    tail = head;
      default:     tail = head;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    cmd_d       = cmd_q;
    x_d         = x_q;
    y_d         = y_q;
    above_d     = above_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_SWEEP;
          cnt_d   = '0;
          cmd_d   = cmd_e'(command_i);
          x_d     = x_index_i;
          y_d     = y_index_i;
          res_d   = '0;
        end
      end
      ST_SWEEP: begin
        if (shift) begin
          above_d = head;
          if (hit) begin
            res_d = tail;
          end
          if (cnt_q == LAST) begin
            state_d     = ST_IDLE;
            out_d       = res_d;
            out_valid_d = 1'b1;
          end else begin
            cnt_d = cnt_q + IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    x_q     <= x_d;
    y_q     <= y_d;
    above_q <= above_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign line_bits_o = LINE_BITS_W'(out_q);

  `LGGE_ASSERT_NEXT(a_accept_starts_sweep, in_fire, state_q == ST_SWEEP, "accepted transaction did not start a sweep")
  `LGGE_ASSERT_IMPL(a_cnt_in_range, state_q == ST_SWEEP, cnt_q <= LAST, "sweep counter beyond last line")
  `LGGE_ASSERT_NEXT(a_sweep_end_result, (state_q == ST_SWEEP) && (cnt_q == LAST) && out_free, out_valid_q && (state_q == ST_IDLE), "sweep end did not deliver a result")
  `LGGE_ASSERT_NEXT(a_no_shift_idle, state_q == ST_IDLE && !in_fire, $stable(head), "chain moved while idle")

endmodule
